FILE: sv/sens_pkg.sv
// ----------------------------------------------------------------------------
// sens_pkg
// shared widths, register indexes and fixed-point constants of the spectrum
// envelope normaliser and smoother
// ----------------------------------------------------------------------------
`default_nettype none

package sens_pkg;

    // payload widths
    localparam int MAG_W      = 16;
    localparam int LEVEL_W    = 16;
    localparam int BAND_IDX_W = 5;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_USE_ENVELOPE     = 1'd0;
    localparam cfg_idx_t CFG_SMOOTHING_WEIGHT = 1'd1;

    localparam logic        USE_ENVELOPE_RST     = 1'b1;
    localparam logic [15:0] SMOOTHING_WEIGHT_RST = 16'd6554;

    // results per frame are capped at this many
    localparam int OUT_LIMIT = 32;

    // datapath widths
    localparam int PEAK_W = 32;
    localparam int MUL_W  = 17;
    localparam int PROD_W = 34;

    // quotient bits produced by the divider, one per cycle
    localparam int DIV_STEPS = 16;

    localparam logic [MUL_W-1:0]   ONE_Q16    = 17'h10000;
    localparam logic [PROD_W-1:0]  ROUND_HALF = 34'h0_0000_8000;
    localparam logic [LEVEL_W-1:0] Q16_MAX    = 16'hFFFF;

endpackage : sens_pkg

`default_nettype wire

FILE: sv/sens_ram.sv
// ----------------------------------------------------------------------------
// sens_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module sens_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule : sens_ram

`default_nettype wire

FILE: sv/spectrum_envelope_normalize_smooth.sv
// ----------------------------------------------------------------------------
// spectrum_envelope_normalize_smooth
// frame-based band normaliser with tilt envelope and exponential smoothing
// ----------------------------------------------------------------------------
// Collects one frame of BINS band magnitudes, one per request on the s_ side,
// in band order. When the last band of a frame lands, s_ready drops and a
// small sequencer walks the frame twice around one shared 17x17 multiplier
// and one shared compare/subtract divider. The first pass (S_PEAK_RD,
// S_PEAK_MUL, S_PEAK_CMP per band) weights each band by the built-in Bezier
// tilt table when use_envelope is set and tracks the frame peak. The second
// pass, which waits out any m_ready stall, fetches and weights the band
// (S_BAND_RD, S_BAND_MUL), sets up (S_DIV_INIT), runs the 16-step
// bit-at-a-time division of the band by the peak (S_DIV, one quotient bit a
// cycle), forms the two smoothing products and their sum (S_MIX1 to S_MIX3),
// and presents the smoothed level on m_ as one request (S_OUT). A band equal
// to the peak, or any band of a silent frame, skips the division. Only the
// first 32 bands of a frame produce a result; m_last_band marks the last band
// or the 32nd. The smoothed levels read as zero after reset; configuration
// is to be written only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module spectrum_envelope_normalize_smooth #(
    parameter int BINS = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    // configuration
    input  logic                          cfg_we,
    input  logic [sens_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sens_pkg::CFG_DATA_W-1:0] cfg_data,

    // band magnitudes in
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [sens_pkg::MAG_W-1:0]    s_magnitude,

    // smoothed levels out
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [sens_pkg::BAND_IDX_W-1:0] m_band_index,
    output logic [sens_pkg::LEVEL_W-1:0]  m_level,
    output logic                          m_last_band
);

    import sens_pkg::*;

    localparam int IDX_W = $clog2(BINS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BINS - 1);

    // sequencer states
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_PEAK_RD  = 4'd1;
    localparam logic [3:0] S_PEAK_MUL = 4'd2;
    localparam logic [3:0] S_PEAK_CMP = 4'd3;
    localparam logic [3:0] S_BAND_RD  = 4'd4;
    localparam logic [3:0] S_BAND_MUL = 4'd5;
    localparam logic [3:0] S_DIV_INIT = 4'd6;
    localparam logic [3:0] S_DIV      = 4'd7;
    localparam logic [3:0] S_MIX1     = 4'd8;
    localparam logic [3:0] S_MIX2     = 4'd9;
    localparam logic [3:0] S_MIX3     = 4'd10;
    localparam logic [3:0] S_OUT      = 4'd11;

    // ------------------------------------------------------------------
    // tilt envelope table, worked out at elaboration
    // 20*n^3*x(i/n) = (n-i)^3 + 6(n-i)^2 i + 12(n-i) i^2 + 20 i^3
    // ------------------------------------------------------------------
    logic [LEVEL_W-1:0] tilt_rom [BINS];

    for (genvar g = 0; g < BINS; g++) begin : g_tilt
        localparam longint unsigned TN  = BINS - 1;
        localparam longint unsigned TI  = g;
        localparam longint unsigned TR  = TN - TI;
        localparam longint unsigned NUM = TR * TR * TR + 6 * TR * TR * TI
                                        + 12 * TR * TI * TI + 20 * TI * TI * TI;
        localparam longint unsigned DEN = 20 * TN * TN * TN;
        localparam longint unsigned QV  = (NUM * 65536 + DEN / 2) / DEN;
        assign tilt_rom[g] = (QV > 65535) ? Q16_MAX : LEVEL_W'(QV);
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    logic [3:0]          state_reg,    state_next;
    logic [IDX_W-1:0]    band_cnt_reg, band_cnt_next;
    logic [IDX_W-1:0]    idx_reg,      idx_next;
    logic [3:0]          bit_cnt_reg,  bit_cnt_next;
    logic [BINS-1:0]     sm_vld_reg,   sm_vld_next;
    logic                use_env_reg,  use_env_next;
    logic [15:0]         weight_reg,   weight_next;
    logic                m_valid_reg,  m_valid_next;

    logic [PEAK_W-1:0]   peak_reg,     peak_next;
    logic [PROD_W-1:0]   prod_reg,     prod_next;
    logic [PROD_W-1:0]   acc_reg,      acc_next;
    logic [PEAK_W-1:0]   rem_reg,      rem_next;
    logic [LEVEL_W-1:0]  quo_reg,      quo_next;
    logic [LEVEL_W-1:0]  s_old_reg,    s_old_next;
    logic                sm_hit_reg,   sm_hit_next;
    logic [BAND_IDX_W-1:0] band_idx_reg, band_idx_next;
    logic [LEVEL_W-1:0]  level_reg,    level_next;
    logic                last_reg,     last_next;

    // ------------------------------------------------------------------
    // memories
    // ------------------------------------------------------------------
    logic               in_take;
    logic               frame_re;
    logic [MAG_W-1:0]   frame_rdata;
    logic               sm_we;
    logic               sm_re;
    logic [LEVEL_W-1:0] sm_rdata;
    logic [LEVEL_W-1:0] sm_wdata;

    assign in_take  = s_valid && s_ready;
    assign frame_re = (state_reg == S_PEAK_RD) || (state_reg == S_BAND_RD);
    assign sm_re    = (state_reg == S_BAND_RD);
    assign sm_we    = (state_reg == S_MIX3);

    // raw magnitudes of the frame being collected
    sens_ram #(
        .WIDTH (MAG_W),
        .DEPTH (BINS)
    ) u_frame_ram (
        .clk   (aclk),
        .we    (in_take),
        .waddr (band_cnt_reg),
        .wdata (s_magnitude),
        .re    (frame_re),
        .raddr (idx_reg),
        .rdata (frame_rdata)
    );

    // smoothed levels kept across frames
    sens_ram #(
        .WIDTH (LEVEL_W),
        .DEPTH (BINS)
    ) u_smooth_ram (
        .clk   (aclk),
        .we    (sm_we),
        .waddr (idx_reg),
        .wdata (sm_wdata),
        .re    (sm_re),
        .raddr (idx_reg),
        .rdata (sm_rdata)
    );

    // ------------------------------------------------------------------
    // shared multiplier
    // ------------------------------------------------------------------
    logic [MUL_W-1:0]  mul_a;
    logic [MUL_W-1:0]  mul_b;
    logic [PROD_W-1:0] mul_p;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg) inside
            S_PEAK_MUL, S_BAND_MUL: begin
                // band magnitude, weighted by the tilt when enabled
                mul_a = {1'b0, frame_rdata};
                mul_b = use_env_reg ? {1'b0, tilt_rom[idx_reg]} : MUL_W'(1);
            end
            S_MIX1: begin
                // new contribution, n * w
                mul_a = {1'b0, quo_reg};
                mul_b = {1'b0, weight_reg};
            end
            S_MIX2: begin
                // kept contribution, s * (1 - w)
                mul_a = {1'b0, s_old_reg};
                mul_b = ONE_Q16 - {1'b0, weight_reg};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // ------------------------------------------------------------------
    // shared divider step: restoring, one quotient bit per cycle
    // ------------------------------------------------------------------
    logic [PEAK_W:0]   div_shift;
    logic              div_ge;
    logic [PEAK_W:0]   div_diff;

    assign div_shift = {rem_reg, 1'b0};
    assign div_ge    = div_shift >= {1'b0, peak_reg};
    assign div_diff  = div_shift - {1'b0, peak_reg};

    // smoothed sum and its rounded level
    logic [PROD_W-1:0] mix_sum;
    assign mix_sum  = acc_reg + prod_reg;
    assign sm_wdata = mix_sum[31:16];

    // band position flags for the result
    logic band_emit;
    logic band_last;
    assign band_emit = 32'(idx_reg) < OUT_LIMIT;
    assign band_last = (idx_reg == LAST_IDX) || (32'(idx_reg) == OUT_LIMIT - 1);

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next    = state_reg;
        band_cnt_next = band_cnt_reg;
        idx_next      = idx_reg;
        bit_cnt_next  = bit_cnt_reg;
        sm_vld_next   = sm_vld_reg;
        use_env_next  = use_env_reg;
        weight_next   = weight_reg;
        m_valid_next  = m_valid_reg;
        peak_next     = peak_reg;
        prod_next     = prod_reg;
        acc_next      = acc_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        s_old_next    = s_old_reg;
        sm_hit_next   = sm_hit_reg;
        band_idx_next = band_idx_reg;
        level_next    = level_reg;
        last_next     = last_reg;

        // register writes, taken whenever offered
        if (cfg_we) begin
            unique case (cfg_index)
                CFG_USE_ENVELOPE:     use_env_next = cfg_data[0];
                CFG_SMOOTHING_WEIGHT: weight_next  = cfg_data[15:0];
            endcase
        end

        unique case (state_reg)
            S_IDLE: begin
                if (in_take) begin
                    if (band_cnt_reg == LAST_IDX) begin
                        // frame complete, start the peak pass
                        band_cnt_next = '0;
                        idx_next      = '0;
                        peak_next     = '0;
                        state_next    = S_PEAK_RD;
                    end else begin
                        band_cnt_next = band_cnt_reg + 1'b1;
                    end
                end
            end
            S_PEAK_RD: begin
                state_next = S_PEAK_MUL;
            end
            S_PEAK_MUL: begin
                prod_next  = mul_p;
                state_next = S_PEAK_CMP;
            end
            S_PEAK_CMP: begin
                if (prod_reg[PEAK_W-1:0] > peak_reg) begin
                    peak_next = prod_reg[PEAK_W-1:0];
                end
                if (idx_reg == LAST_IDX) begin
                    idx_next   = '0;
                    state_next = S_BAND_RD;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_PEAK_RD;
                end
            end
            S_BAND_RD: begin
                sm_hit_next = sm_vld_reg[idx_reg];
                state_next  = S_BAND_MUL;
            end
            S_BAND_MUL: begin
                prod_next  = mul_p;
                s_old_next = sm_hit_reg ? sm_rdata : '0;
                state_next = S_DIV_INIT;
            end
            S_DIV_INIT: begin
                if (peak_reg == '0) begin
                    quo_next   = '0;
                    state_next = S_MIX1;
                end else if (prod_reg[PEAK_W-1:0] == peak_reg) begin
                    // exactly one saturates
                    quo_next   = Q16_MAX;
                    state_next = S_MIX1;
                end else begin
                    rem_next     = prod_reg[PEAK_W-1:0];
                    quo_next     = '0;
                    bit_cnt_next = '0;
                    state_next   = S_DIV;
                end
            end
            S_DIV: begin
                rem_next     = div_ge ? div_diff[PEAK_W-1:0] : div_shift[PEAK_W-1:0];
                quo_next     = {quo_reg[LEVEL_W-2:0], div_ge};
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == 4'(DIV_STEPS - 1)) begin
                    state_next = S_MIX1;
                end
            end
            S_MIX1: begin
                prod_next  = mul_p;
                state_next = S_MIX2;
            end
            S_MIX2: begin
                acc_next   = prod_reg + ROUND_HALF;
                prod_next  = mul_p;
                state_next = S_MIX3;
            end
            S_MIX3: begin
                sm_vld_next[idx_reg] = 1'b1;
                if (band_emit) begin
                    m_valid_next  = 1'b1;
                    band_idx_next = BAND_IDX_W'(idx_reg);
                    level_next    = sm_wdata;
                    last_next     = band_last;
                    state_next    = S_OUT;
                end else if (idx_reg == LAST_IDX) begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_BAND_RD;
                end
            end
            S_OUT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    if (idx_reg == LAST_IDX) begin
                        idx_next   = '0;
                        state_next = S_IDLE;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_BAND_RD;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            band_cnt_reg <= '0;
            idx_reg      <= '0;
            bit_cnt_reg  <= '0;
            sm_vld_reg   <= '0;
            use_env_reg  <= USE_ENVELOPE_RST;
            weight_reg   <= SMOOTHING_WEIGHT_RST;
            m_valid_reg  <= 1'b0;
            peak_reg     <= '0;
        end else begin
            state_reg    <= state_next;
            band_cnt_reg <= band_cnt_next;
            idx_reg      <= idx_next;
            bit_cnt_reg  <= bit_cnt_next;
            sm_vld_reg   <= sm_vld_next;
            use_env_reg  <= use_env_next;
            weight_reg   <= weight_next;
            m_valid_reg  <= m_valid_next;
            peak_reg     <= peak_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        s_old_reg    <= s_old_next;
        sm_hit_reg   <= sm_hit_next;
        band_idx_reg <= band_idx_next;
        level_reg    <= level_next;
        last_reg     <= last_next;
    end

    assign s_ready      = (state_reg == S_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_band_index = band_idx_reg;
    assign m_level      = level_reg;
    assign m_last_band  = last_reg;

`ifndef SYNTH
    // no result may be pending while new bands are being taken
    a_idle_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !m_valid_reg)
        else $error("result pending while collecting bands");

    // the divider remainder always stays below the peak
    a_div_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |-> (rem_reg < peak_reg))
        else $error("divider remainder not below peak");

    // the final band's result hands the block back to collection
    a_frame_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && (idx_reg == LAST_IDX)) |=> s_ready)
        else $error("block not idle after final band");

    // a result is only flagged last on the final or the capped band
    a_last_position: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last_band) |-> band_last)
        else $error("last band flag on wrong band");
`endif

endmodule : spectrum_envelope_normalize_smooth

`default_nettype wire

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the spectrum envelope normaliser and smoother
// ----------------------------------------------------------------------------
// Frames of band magnitudes are queued by a stimulus sequence and fed to the
// s_ side by a clocked driver. Every accepted band is also folded into a
// local model of the block: tilt weighting, peak search, Q0.16 normalisation
// and exponential smoothing. Each finished frame yields the smoothed levels
// that the m_ side must return. A clocked monitor checks every m_ request
// against the oldest expected level. Both sides insert random gaps. Once in
// the run the receiver holds off long enough for the block to stall its
// input. Registers are written only while the block is idle.
// ----------------------------------------------------------------------------

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import sens_pkg::*;

    localparam int          BINS         = 32;
    localparam int unsigned HOLD_CYCLES  = 3000;
    localparam int unsigned TAIL_CYCLES  = 28 * BINS + 64;
    localparam int unsigned CYCLE_LIMIT  = 400000;

    // kinds of frame the stimulus can build
    typedef enum int {
        FRAME_EDGES,
        FRAME_NOISE,
        FRAME_SILENT,
        FRAME_FLAT_MAX,
        FRAME_SPIKE,
        FRAME_FAINT
    } frame_kind_t;

    // one smoothed level as it should appear on the m_ side
    typedef struct packed {
        logic [BAND_IDX_W-1:0] band;
        logic [LEVEL_W-1:0]    level;
        logic                  last;
    } level_rec_t;

    // clock, reset and block ports, all known from time zero
    logic                  aclk         = 1'b0;
    logic                  aresetn      = 1'b0;
    logic                  cfg_we       = 1'b0;
    cfg_idx_t              cfg_index    = CFG_USE_ENVELOPE;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;
    logic                  s_valid      = 1'b0;
    logic                  s_ready;
    logic [MAG_W-1:0]      s_magnitude  = '0;
    logic                  m_valid;
    logic                  m_ready      = 1'b0;
    logic [BAND_IDX_W-1:0] m_band_index;
    logic [LEVEL_W-1:0]    m_level;
    logic                  m_last_band;

    // magnitudes waiting to be offered, smoothed levels waiting to come back
    logic [MAG_W-1:0] magnitude_backlog [$];
    level_rec_t       expected_levels   [$];

    // local copy of the block's state and registers
    logic [MAG_W-1:0]   frame_mag   [BINS];
    logic [15:0]        tilt_q16    [BINS];
    logic [LEVEL_W-1:0] smooth_lvl  [BINS];
    int                 bands_held  = 0;
    logic               env_on      = USE_ENVELOPE_RST;
    logic [15:0]        blend_weight = SMOOTHING_WEIGHT_RST;

    // pacing of both sides
    bit          steady_flow  = 1'b0;
    bit          hold_wanted  = 1'b0;
    bit          hold_done    = 1'b0;
    int unsigned send_gap     = 0;
    int unsigned ready_gap    = 0;
    int unsigned hold_left    = 0;
    int unsigned cycle_count  = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches   = 0;

    spectrum_envelope_normalize_smooth #(
        .BINS(BINS)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_magnitude (s_magnitude),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_band_index(m_band_index),
        .m_level     (m_level),
        .m_last_band (m_last_band)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // mostly short gaps, now and then a long one; none while the flow is steady
    function automatic int unsigned pick_gap(input bit steady);
        int unsigned roll;
        if (steady)
            return 0;
        roll = $urandom_range(99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(3, 1);
        if (roll < 97)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    // random frame kind, weighted towards full-range noise
    function automatic frame_kind_t pick_kind();
        int unsigned roll;
        roll = $urandom_range(9);
        case (roll)
            0: return FRAME_SILENT;
            1: return FRAME_FLAT_MAX;
            2: return FRAME_SPIKE;
            3: return FRAME_FAINT;
            default: return FRAME_NOISE;
        endcase
    endfunction

    // queue bands first .. first+count-1 of a frame of the given kind
    task automatic queue_frame(input frame_kind_t kind, input int first, input int count);
        int          spike_at;
        logic [15:0] mag;
        spike_at = $urandom_range(BINS - 1);
        for (int b = first; b < first + count; b++) begin
            case (kind)
                FRAME_EDGES: begin
                    // extremes and alternating patterns; the top band at full
                    // scale so that it equals the peak with the tilt applied
                    case (b % 8)
                        0: mag = 16'hFFFF;
                        1: mag = 16'h0000;
                        2: mag = 16'h0001;
                        3: mag = 16'h8000;
                        4: mag = 16'h5555;
                        5: mag = 16'hAAAA;
                        6: mag = 16'h00FF;
                        default: mag = 16'hFF00;
                    endcase
                    if (b == BINS - 1)
                        mag = 16'hFFFF;
                end
                FRAME_SILENT:   mag = 16'h0000;
                FRAME_FLAT_MAX: mag = 16'hFFFF;
                FRAME_SPIKE:    mag = (b == spike_at) ? 16'hFFFF : 16'($urandom_range(255));
                FRAME_FAINT:    mag = 16'($urandom_range(15));
                default:        mag = 16'($urandom);
            endcase
            magnitude_backlog.insert(magnitude_backlog.size(), mag);
        end
    endtask

    // fold one accepted band into the frame; at the frame's last band work
    // out the weighted values, the peak, the normalised bands and the new
    // smoothed levels, and queue what the block must emit
    task automatic predict_smoothed_levels(input logic [MAG_W-1:0] mag);
        logic [31:0] weighted [BINS];
        logic [31:0] peak;
        logic [63:0] norm;
        logic [63:0] blend;
        level_rec_t  rec;
        frame_mag[bands_held] = mag;
        bands_held++;
        if (bands_held == BINS) begin
            bands_held = 0;
            peak = '0;
            for (int b = 0; b < BINS; b++) begin
                weighted[b] = env_on ? 32'(frame_mag[b]) * 32'(tilt_q16[b])
                                     : 32'(frame_mag[b]);
                if (weighted[b] > peak)
                    peak = weighted[b];
            end
            for (int b = 0; b < BINS; b++) begin
                // a silent frame skips the division and normalises to zero
                norm = '0;
                if (peak != 0) begin
                    norm = (64'(weighted[b]) << 16) / 64'(peak);
                    if (norm > 64'(Q16_MAX))
                        norm = 64'(Q16_MAX);
                end
                blend = norm * 64'(blend_weight)
                      + 64'(smooth_lvl[b]) * (64'd65536 - 64'(blend_weight))
                      + 64'd32768;
                smooth_lvl[b] = blend[31:16];
                if (b < OUT_LIMIT) begin
                    rec.band  = BAND_IDX_W'(b);
                    rec.level = smooth_lvl[b];
                    rec.last  = (b == BINS - 1) || (b == OUT_LIMIT - 1);
                    expected_levels.insert(expected_levels.size(), rec);
                end
            end
        end
    endtask

    // one register write, mirrored into the local copy; only the low bit
    // of the envelope register counts
    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_USE_ENVELOPE)
            env_on = value[0];
        else
            blend_weight = value[15:0];
    endtask

    // wait until every band is in and every level is back, then let the
    // block settle
    task automatic await_idle(input int unsigned settle);
        do
            @(negedge aclk);
        while (magnitude_backlog.size() != 0 || s_valid || expected_levels.size() != 0);
        repeat (settle) @(posedge aclk);
    endtask

    // driver: offers the backlog on the s_ side, one request at a time,
    // holding valid and payload until taken
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid     <= 1'b0;
            s_magnitude <= '0;
            send_gap    <= 0;
        end else begin
            if (s_valid && s_ready)
                predict_smoothed_levels(s_magnitude);
            // the slot is free when nothing is offered or the offer was taken
            if (!s_valid || s_ready) begin
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                    s_valid  <= 1'b0;
                end else if (magnitude_backlog.size() != 0) begin
                    s_valid     <= 1'b1;
                    s_magnitude <= magnitude_backlog.pop_front();
                    send_gap    <= pick_gap(steady_flow);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver readiness: random stalls, plus one long hold-off that starts
    // at the first offered level after it is asked for
    always @(posedge aclk) begin : ready_pacing
        int unsigned g;
        if (!aresetn) begin
            m_ready   <= 1'b0;
            ready_gap <= 0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (hold_wanted && !hold_done && m_valid) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (ready_gap != 0) begin
            ready_gap <= ready_gap - 1;
            m_ready   <= 1'b0;
        end else if (m_valid && m_ready) begin
            g = pick_gap(steady_flow);
            ready_gap <= (g != 0) ? g - 1 : 0;
            m_ready   <= (g == 0);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // monitor: every m_ request against the oldest expected level
    always @(posedge aclk) begin : level_monitor
        level_rec_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen <= results_seen + 1;
            if (expected_levels.size() == 0) begin
                $error("unexpected level: band_index %0d level %0d last_band %0b",
                       m_band_index, m_level, m_last_band);
                mismatches++;
            end else begin
                want = expected_levels.pop_front();
                if (m_band_index !== want.band) begin
                    $error("band_index: expected %0d, got %0d", want.band, m_band_index);
                    mismatches++;
                end
                if (m_level !== want.level) begin
                    $error("level: expected %0d, got %0d", want.level, m_level);
                    mismatches++;
                end
                if (m_last_band !== want.last) begin
                    $error("last_band: expected %0b, got %0b", want.last, m_last_band);
                    mismatches++;
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // stimulus sequence
    initial begin
        logic [63:0] r, n, num, den, q;

        // tilt envelope: x(t) of the Bezier curve with x control points
        // 0.05, 0.1, 0.2 and 1.0, scaled by 20*n^3 to stay in integers
        n = 64'(BINS - 1);
        for (int b = 0; b < BINS; b++) begin
            r   = n - 64'(b);
            num = r * r * r + 64'd6 * r * r * 64'(b) + 64'd12 * r * 64'(b) * 64'(b)
                + 64'd20 * 64'(b) * 64'(b) * 64'(b);
            den = 64'd20 * n * n * n;
            q   = (num * 64'd65536 + den / 2) / den;
            tilt_q16[b]   = (q > 64'(Q16_MAX)) ? Q16_MAX : q[15:0];
            smooth_lvl[b] = '0;
            frame_mag[b]  = '0;
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings, hand-picked edge frame
        queue_frame(FRAME_EDGES, 0, BINS);
        await_idle(TAIL_CYCLES);

        // envelope off (junk in the unused upper bits), new frame takes over
        // completely; every band at the peak, then a silent frame
        write_reg(CFG_USE_ENVELOPE, {15'($urandom), 1'b0});
        write_reg(CFG_SMOOTHING_WEIGHT, 16'hFFFF);
        queue_frame(FRAME_FLAT_MAX, 0, BINS);
        queue_frame(FRAME_SILENT, 0, BINS);
        await_idle(TAIL_CYCLES);

        // zero weight holds the levels; no idling on either side
        write_reg(CFG_SMOOTHING_WEIGHT, 16'h0000);
        steady_flow <= 1'b1;
        queue_frame(pick_kind(), 0, BINS);
        await_idle(TAIL_CYCLES);

        // envelope back on, random weight; stop part-way into a frame
        write_reg(CFG_USE_ENVELOPE, 16'h0001);
        write_reg(CFG_SMOOTHING_WEIGHT, 16'($urandom));
        queue_frame(pick_kind(), 0, BINS);
        queue_frame(FRAME_NOISE, 0, 10);
        await_idle(TAIL_CYCLES);

        // envelope switched off in the middle of a frame, smallest weight;
        // the receiver holds off once so that the block backs up
        steady_flow <= 1'b0;
        write_reg(CFG_USE_ENVELOPE, 16'h0000);
        write_reg(CFG_SMOOTHING_WEIGHT, 16'h0001);
        hold_wanted <= 1'b1;
        queue_frame(FRAME_NOISE, 10, BINS - 10);
        queue_frame(pick_kind(), 0, BINS);
        queue_frame(pick_kind(), 0, BINS);
        await_idle(TAIL_CYCLES);

        // half weight with the envelope
        write_reg(CFG_USE_ENVELOPE, 16'hFFFF);
        write_reg(CFG_SMOOTHING_WEIGHT, 16'h8000);
        queue_frame(pick_kind(), 0, BINS);
        await_idle(TAIL_CYCLES);

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule : testbench

FILE: filelist.f
sv/sens_pkg.sv
sv/sens_ram.sv
sv/spectrum_envelope_normalize_smooth.sv
bench/testbench.sv
